FILE: rtl/htx_pkg.sv
// Shared types and constants for the homogeneous 4x4 transform.
`timescale 1ns / 1ps

package htx_pkg;

  localparam int DATA_WIDTH = 24;
  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int LANE_BITS  = 16;
  localparam int NUM_LANES  = 4;

  localparam int CFG_WIDTH = 64;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int ROW_IDX_W = $clog2(NUM_LANES);

  // Register map: forward rows first, then inverse rows.
  localparam logic [CFG_IDX_W-1:0] REG_FWD_ROW0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0 = CFG_IDX_W'(4);

  localparam logic CMD_FWD    = 1'b0;
  localparam logic CMD_NORMAL = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef data_t [NUM_LANES-1:0] data_vec_t;
  typedef coef_t [NUM_LANES-1:0] coef_vec_t;
  typedef coef_vec_t [NUM_LANES-1:0] coef_mat_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic  cmd;
    data_t in_x;
    data_t in_y;
    data_t in_z;
    data_t in_w;
  } in_word_t;

  typedef struct packed {
    data_t out_x;
    data_t out_y;
    data_t out_z;
    data_t out_w;
    logic  overflow;
  } out_word_t;

  // Per-stage load enables shared by all lanes.
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctrl_t;

endpackage

FILE: rtl/htx_cfg.sv
// Matrix register bank and per-lane coefficient selection.
`timescale 1ns / 1ps

module htx_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [htx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [htx_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                              cmd,
  output htx_pkg::coef_mat_t                coefs
);
  import htx_pkg::*;

  logic [CFG_WIDTH-1:0] fwd_rows [NUM_LANES];
  logic [CFG_WIDTH-1:0] inv_rows [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_LANES; r++) begin
        fwd_rows[r] <= CFG_WIDTH'(1) << (FRAC_BITS + LANE_BITS * r);
        inv_rows[r] <= CFG_WIDTH'(1) << (FRAC_BITS + LANE_BITS * r);
      end
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      if (cfg_index >= REG_INV_ROW0) begin
        inv_rows[cfg_index[ROW_IDX_W-1:0]] <= cfg_data;
      end else begin
        fwd_rows[cfg_index[ROW_IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  // Lane i takes row i of the forward matrix, or column i of the inverse.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        if (cmd == CMD_NORMAL) begin
          coefs[i][j] = inv_rows[j][LANE_BITS*i +: COEF_WIDTH];
        end else begin
          coefs[i][j] = fwd_rows[i][LANE_BITS*j +: COEF_WIDTH];
        end
      end
    end
  end

endmodule

FILE: rtl/htx_lane.sv
// One output component: four products, sum, floor shift and saturation.
`timescale 1ns / 1ps

module htx_lane (
  input  logic                 clk,
  input  htx_pkg::lane_ctrl_t  ctrl,
  input  htx_pkg::coef_vec_t   coefs,
  input  htx_pkg::data_vec_t   comps,
  output htx_pkg::data_t       result,
  output logic                 sat
);
  import htx_pkg::*;

  localparam int PROD_W = COEF_WIDTH + DATA_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod [NUM_LANES];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh;
  logic                     fits;

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        prod[j] <= PROD_W'($signed(coefs[j]) * $signed(comps[j]));
      end
    end
  end

  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    // arithmetic shift rounds toward minus infinity
    sh = SH_W'(sum >>> FRAC_BITS);
    fits = (&sh[SH_W-1:DATA_WIDTH-1]) || !(|sh[SH_W-1:DATA_WIDTH-1]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_sum) begin
      sat <= !fits;
      if (fits) begin
        result <= sh[DATA_WIDTH-1:0];
      end else begin
        result <= sh[SH_W-1] ? DATA_MIN : DATA_MAX;
      end
    end
  end

endmodule

FILE: rtl/htx_merge.sv
// Output register: gathers the lane results and merges the saturation flags.
`timescale 1ns / 1ps

module htx_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic                              lanes_valid,
  input  htx_pkg::data_vec_t                results,
  input  logic [htx_pkg::NUM_LANES-1:0]     sats,
  output logic                              out_valid,
  output htx_pkg::out_word_t                out_word
);
  import htx_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= lanes_valid;
    end
    if (load && lanes_valid) begin
      out_word.out_x    <= results[0];
      out_word.out_y    <= results[1];
      out_word.out_z    <= results[2];
      out_word.out_w    <= results[3];
      out_word.overflow <= |sats;
    end
  end

endmodule

FILE: rtl/homogeneous_transform_4x4_top.sv
// Top level of the homogeneous 4x4 matrix-vector transform.
//
// Usage:
//   Input channel (in_valid/in_ready/in_word) carries one vector per word with
//   a command: forward matrix, or the transpose of the inverse matrix for
//   normals. Output channel (out_valid/out_ready/out_word) returns the four
//   saturated Q11.12 components and an overflow flag, one word per input word,
//   in order.
//   Matrices are written through cfg_we/cfg_index/cfg_data, one 64-bit row per
//   write, while no words are in flight. Indexes eight and up are ignored.
// Timing:
//   An accepted word passes the product stage, then the sum and saturate stage,
//   then the output register, before out_valid. One word per cycle sustained
//   while out_ready stays high; the four lanes each own four 16x24 multipliers,
//   so every word enters the product stage as it is accepted.
// Reset:
//   rst clears all valid bits and loads identity into both matrices.
// Stall:
//   When out_ready is low the output register holds; the internal stages keep
//   accepting until each holds a word, then in_ready drops.
`timescale 1ns / 1ps

module homogeneous_transform_4x4_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [htx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [htx_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  htx_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output htx_pkg::out_word_t                out_word
);
  import htx_pkg::*;

  coef_mat_t                coefs;
  data_vec_t                comps;
  data_vec_t                results;
  logic [NUM_LANES-1:0]     sats;
  lane_ctrl_t               ctrl;
  logic                     mul_valid;
  logic                     sum_valid;
  logic                     en_out;

  assign comps = {in_word.in_w, in_word.in_z, in_word.in_y, in_word.in_x};

  // Each stage advances when it is empty or the stage after it moves.
  assign en_out      = !out_valid || out_ready;
  assign ctrl.en_sum = !sum_valid || en_out;
  assign ctrl.en_mul = !mul_valid || !sum_valid || en_out;
  assign in_ready    = ctrl.en_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (ctrl.en_mul) begin
        mul_valid <= in_valid;
      end
      if (ctrl.en_sum) begin
        sum_valid <= mul_valid;
      end
    end
  end

  htx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (in_word.cmd),
    .coefs     (coefs)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    htx_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .coefs  (coefs[i]),
      .comps  (comps),
      .result (results[i]),
      .sat    (sats[i])
    );
  end

  htx_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (en_out),
    .lanes_valid (sum_valid),
    .results     (results),
    .sats        (sats),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

  a_accept_fills_mul: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> mul_valid)
    else $error("accepted word did not reach the product stage");

  a_empty_pipe_ready: assert property (@(posedge clk) disable iff (rst)
    !mul_valid |-> in_ready)
    else $error("input stalled with an empty product stage");

  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !en_out |=> sum_valid)
    else $error("sum stage dropped a word while the output stalled");

  a_overflow_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.overflow |->
      out_word.out_x == DATA_MAX || out_word.out_x == DATA_MIN ||
      out_word.out_y == DATA_MAX || out_word.out_y == DATA_MIN ||
      out_word.out_z == DATA_MAX || out_word.out_z == DATA_MIN ||
      out_word.out_w == DATA_MAX || out_word.out_w == DATA_MIN)
    else $error("overflow flagged without a clamped component");

endmodule

FILE: test/htx_checker.sv
// Checker for the 4x4 transform: tracks the matrices, predicts each output word, compares.
`timescale 1ns / 1ps

module htx_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [htx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htx_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  htx_pkg::in_word_t             in_word,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  htx_pkg::out_word_t            out_word,
  output int                            mismatches,
  output int                            pending,
  output int                            checked_words,
  output int                            saturated_words
);
  import htx_pkg::*;

  logic [CFG_WIDTH-1:0] fwd_rows [NUM_LANES];
  logic [CFG_WIDTH-1:0] inv_rows [NUM_LANES];
  out_word_t            expected_words [$];

  // Forward matrix for points, transpose of the inverse for normals;
  // each sum is floored by the fraction shift and clamped to the data width.
  function automatic out_word_t transform_vector(in_word_t w);
    longint    comp [NUM_LANES];
    longint    acc;
    longint    res;
    coef_t     c;
    data_t     lanes [NUM_LANES];
    out_word_t o;
    comp[0] = longint'(data_t'(w.in_x));
    comp[1] = longint'(data_t'(w.in_y));
    comp[2] = longint'(data_t'(w.in_z));
    comp[3] = longint'(data_t'(w.in_w));
    o = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      acc = 0;
      for (int j = 0; j < NUM_LANES; j++) begin
        if (w.cmd == CMD_NORMAL) begin
          c = inv_rows[j][LANE_BITS*i +: COEF_WIDTH];
        end else begin
          c = fwd_rows[i][LANE_BITS*j +: COEF_WIDTH];
        end
        acc += longint'(c) * comp[j];
      end
      res = acc >>> FRAC_BITS;
      if (res > longint'(DATA_MAX)) begin
        res = longint'(DATA_MAX);
        o.overflow = 1'b1;
      end else if (res < longint'(DATA_MIN)) begin
        res = longint'(DATA_MIN);
        o.overflow = 1'b1;
      end
      lanes[i] = data_t'(res);
    end
    o.out_x = lanes[0];
    o.out_y = lanes[1];
    o.out_z = lanes[2];
    o.out_w = lanes[3];
    return o;
  endfunction

  task automatic check_field(input string name, input data_t want, input data_t got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int r = 0; r < NUM_LANES; r++) begin
        fwd_rows[r] = 64'd1 << (LANE_BITS * r + FRAC_BITS);
        inv_rows[r] = 64'd1 << (LANE_BITS * r + FRAC_BITS);
      end
      expected_words.delete();
      mismatches = 0;
      checked_words = 0;
      saturated_words = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: output word with nothing expected, expected none actual %h",
                   $time, out_word);
        end else begin
          want = expected_words.pop_front();
          checked_words++;
          if (want.overflow) saturated_words++;
          check_field("out_x", want.out_x, out_word.out_x);
          check_field("out_y", want.out_y, out_word.out_y);
          check_field("out_z", want.out_z, out_word.out_z);
          check_field("out_w", want.out_w, out_word.out_w);
          check_field("overflow", data_t'(want.overflow), data_t'(out_word.overflow));
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(transform_vector(in_word));
      end
      // indexes past the register map are dropped
      if (cfg_we && cfg_index < NUM_REGS) begin
        if (cfg_index < REG_INV_ROW0) begin
          fwd_rows[cfg_index[ROW_IDX_W-1:0]] = cfg_data;
        end else begin
          inv_rows[cfg_index[ROW_IDX_W-1:0]] = cfg_data;
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the 4x4 transform: reset, matrix writes, vector stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import htx_pkg::*;

  typedef enum int {COEF_ANY, COEF_UNIT, COEF_EDGE, COEF_NONE} coef_mix_t;
  typedef enum int {VAL_ANY, VAL_NEAR, VAL_EDGE} val_mix_t;

  localparam int    PHASE_WORDS = 50;
  localparam int    NUM_PHASES  = 8;
  localparam data_t ONE         = data_t'(1 << FRAC_BITS);

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_word;

  int mismatches;
  int pending;
  int checked_words;
  int saturated_words;
  int vectors_sent;
  int normals_sent;
  int reg_writes;
  bit idle_on;

  always #4 clk = ~clk;

  homogeneous_transform_4x4_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  htx_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked_words   (checked_words),
    .saturated_words (saturated_words)
  );

  function automatic data_t pick_component(val_mix_t mix);
    data_t v;
    case (mix)
      VAL_NEAR: begin
        v = data_t'($urandom_range(0, 131072)) - data_t'(65536);
      end
      VAL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = DATA_MAX;
          1:       v = DATA_MIN;
          2:       v = '0;
          3:       v = '1;
          default: v = ONE;
        endcase
      end
      default: v = data_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic coef_t pick_coef(coef_mix_t mix);
    coef_t c;
    case (mix)
      COEF_UNIT: c = coef_t'($urandom_range(0, 8192)) - coef_t'(4096);
      COEF_NONE: c = '0;
      COEF_EDGE: begin
        case ($urandom_range(0, 4))
          0:       c = 16'h7fff;
          1:       c = 16'h8000;
          2:       c = 16'hffff;
          3:       c = 16'h0000;
          default: c = coef_t'(1 << FRAC_BITS);
        endcase
      end
      default: c = coef_t'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_row(coef_mix_t mix);
    logic [CFG_WIDTH-1:0] row;
    row = '0;
    for (int j = 0; j < NUM_LANES; j++) row[LANE_BITS*j +: COEF_WIDTH] = pick_coef(mix);
    return row;
  endfunction

  function automatic in_word_t make_vector(logic cmd, data_t x, data_t y, data_t z, data_t w);
    in_word_t v;
    v.cmd  = cmd;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  task automatic write_reg(input int index, input logic [CFG_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index[CFG_IDX_W-1:0];
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  task automatic load_matrices(input coef_mix_t mix);
    for (int r = 0; r < NUM_LANES; r++) begin
      write_reg(REG_FWD_ROW0 + r, pick_row(mix));
      write_reg(REG_INV_ROW0 + r, pick_row(mix));
    end
    // past the register map: must leave both matrices alone
    write_reg(NUM_REGS + $urandom_range(0, 7), {$urandom, $urandom});
  endtask

  // Returns right after the edge that took the word, with valid still high.
  task automatic send_vector(input in_word_t w);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    vectors_sent++;
    if (w.cmd == CMD_NORMAL) normals_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Output side: out_ready drops in random stall bursts while idling is enabled.
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d words outstanding", $time, pending);
    $display("status: fail");
    $finish;
  end

  initial begin
    coef_mix_t            mix;
    in_word_t             w;
    logic [CFG_WIDTH-1:0] row;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_word      = '0;
    idle_on      = 1'b1;
    vectors_sent = 0;
    normals_sent = 0;
    reg_writes   = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // identity after reset, both commands, data extremes
    send_vector(make_vector(CMD_FWD, '0, '0, '0, '0));
    send_vector(make_vector(CMD_FWD, DATA_MAX, DATA_MIN, '1, data_t'(1)));
    send_vector(make_vector(CMD_NORMAL, DATA_MIN, DATA_MAX, data_t'(1), '1));
    send_vector(make_vector(CMD_NORMAL, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN));
    wait_idle();

    // extreme coefficients: drive saturation high and low
    for (int r = 0; r < NUM_LANES; r++) begin
      write_reg(REG_FWD_ROW0 + r, {NUM_LANES{16'h7fff}});
      write_reg(REG_INV_ROW0 + r, {NUM_LANES{16'h8000}});
    end
    send_vector(make_vector(CMD_FWD, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
    send_vector(make_vector(CMD_FWD, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
    send_vector(make_vector(CMD_NORMAL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
    send_vector(make_vector(CMD_NORMAL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
    send_vector(make_vector(CMD_FWD, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN));
    wait_idle();

    // distinct coefficients: a unit vector picks out one column, or one row for normals
    for (int r = 0; r < NUM_LANES; r++) begin
      row = '0;
      for (int j = 0; j < NUM_LANES; j++) begin
        row[LANE_BITS*j +: COEF_WIDTH] = coef_t'((r * NUM_LANES + j + 1) * 256);
      end
      write_reg(REG_FWD_ROW0 + r, row);
      write_reg(REG_INV_ROW0 + r, ~row);
    end
    write_reg(NUM_REGS, '1);
    write_reg(NUM_REGS + 7, '0);
    for (int j = 0; j < NUM_LANES; j++) begin
      for (int k = 0; k < 2; k++) begin
        send_vector(make_vector(k ? CMD_NORMAL : CMD_FWD,
                                (j == 0) ? ONE : '0, (j == 1) ? ONE : '0,
                                (j == 2) ? ONE : '0, (j == 3) ? ONE : '0));
      end
    end

    // random phases, each with freshly loaded matrices; the last one runs without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      idle_on = (p < NUM_PHASES - 1);
      mix = (p == NUM_PHASES - 1) ? COEF_UNIT : coef_mix_t'(p % 4);
      load_matrices(mix);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        w.cmd  = $urandom_range(0, 1) ? CMD_NORMAL : CMD_FWD;
        w.in_x = pick_component(val_mix_t'($urandom_range(0, 2)));
        w.in_y = pick_component(val_mix_t'($urandom_range(0, 2)));
        w.in_z = pick_component(val_mix_t'($urandom_range(0, 2)));
        w.in_w = pick_component(val_mix_t'($urandom_range(0, 2)));
        send_vector(w);
      end
    end
    wait_idle();
    repeat (8) @(negedge clk);

    $display("sent %0d vectors (%0d normals) across %0d register writes and %0d matrix sets",
             vectors_sent, normals_sent, reg_writes, NUM_PHASES + 3);
    $display("checked %0d output words, %0d of them saturated, %0d mismatches",
             checked_words, saturated_words, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/htx_pkg.sv
rtl/htx_cfg.sv
rtl/htx_lane.sv
rtl/htx_merge.sv
rtl/homogeneous_transform_4x4_top.sv
test/htx_checker.sv
test/tb_top.sv
